/* sv/ccm_pkg.sv */
package ccm_pkg;

	localparam int MAX_CODES_DEF    = 64;
	localparam int MAX_CODE_LEN_DEF = 31;

	localparam int CODE_LEN_W  = 5;
	localparam int ERR_W       = 5;
	localparam int COUNT_W     = 7;
	localparam int INDEX_W     = 6;
	localparam int WORD_W      = 31;
	localparam int SLEN_W      = 6;
	localparam int STATUS_W    = 2;
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;
	localparam int S_TDATA_W   = 80;
	localparam int M_TDATA_W   = 8;

	localparam logic [CODE_LEN_W-1:0] CODE_LEN_RST = CODE_LEN_W'(16);

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_MATCH = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_MATCH   = 2'd0,
		ST_INVALID = 2'd1,
		ST_SHORT   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_CODE_LENGTH    = 2'd0,
		REG_ALLOWED_ERRORS = 2'd1,
		REG_CODE_COUNT     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CODE_LEN_W-1:0] code_length;
		logic [ERR_W-1:0]      allowed_errors;
		logic [COUNT_W-1:0]    code_count;
	} cfg_t;

endpackage

/* sv/ccm_ram.sv */
module ccm_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/ccm_dist.sv */
module ccm_dist #(
	parameter int W = 31
) (
	input  logic [W-1:0]              a,
	input  logic [W-1:0]              b,
	input  logic [ccm_pkg::ERR_W-1:0] limit,
	output logic                      hit
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  diff;
	logic [CW-1:0] ones;

	always_comb begin
		diff = a ^ b;
		ones = '0;
		for (int k = 0; k < W; k++) begin
			ones = ones + CW'(diff[k]);
		end
		hit = 32'(ones) <= 32'(limit);
	end

endmodule

/* sv/ccm_regs.sv */
module ccm_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ccm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ccm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ccm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output ccm_pkg::cfg_t                    cfg
);

	ccm_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic          in_map;
	logic [1:0]    reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[3:2];
	assign in_map  = paddr[1:0] == 2'b00;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_length    <= ccm_pkg::CODE_LEN_RST;
			cfg_q.allowed_errors <= '0;
			cfg_q.code_count     <= '0;
		end else if (wr_en && in_map) begin
			case (reg_sel)
				ccm_pkg::REG_CODE_LENGTH:
					cfg_q.code_length <= pwdata[ccm_pkg::CODE_LEN_W-1:0];
				ccm_pkg::REG_ALLOWED_ERRORS:
					cfg_q.allowed_errors <= pwdata[ccm_pkg::ERR_W-1:0];
				ccm_pkg::REG_CODE_COUNT:
					cfg_q.code_count <= pwdata[ccm_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (in_map) begin
			case (reg_sel)
				ccm_pkg::REG_CODE_LENGTH:
					prdata = ccm_pkg::APB_DATA_W'(cfg_q.code_length);
				ccm_pkg::REG_ALLOWED_ERRORS:
					prdata = ccm_pkg::APB_DATA_W'(cfg_q.allowed_errors);
				ccm_pkg::REG_CODE_COUNT:
					prdata = ccm_pkg::APB_DATA_W'(cfg_q.code_count);
				default: prdata = '0;
			endcase
		end
	end

endmodule

/* sv/cyclic_code_match_with_tolerance.sv */
// Rotation-tolerant code matcher. A load item (tuser 0) writes one reference code into the
// table. A match item (tuser 1) compares the first code_length received bits with each
// cyclic rotation of codes 0 .. code_count-1 and returns the first code within
// allowed_errors bit differences, or invalid / too short. One shared rotate-and-popcount
// unit checks one rotation per cycle; each code is searched by a table read, a fetch and a
// rotation walk, and the walk stops early when a rotation hits. The length check or an
// empty table decides the result without a search.
// The block takes no item during a search; a result held by m_tready stalls the next match.
module cyclic_code_match_with_tolerance #(
	parameter int MAX_CODES    = ccm_pkg::MAX_CODES_DEF,
	parameter int MAX_CODE_LEN = ccm_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ccm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ccm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ccm_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// code_index[5:0], code_word[36:6], signal_bits[67:37], signal_length[73:68], zeros
	input  logic [ccm_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[1:0], matched_index[7:2]
	output logic [ccm_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int L     = MAX_CODE_LEN;
	localparam int IDX_W = $clog2(MAX_CODES > 1 ? MAX_CODES : 2);
	localparam int CNT_W = $clog2(MAX_CODES + 1);
	localparam int LW    = ccm_pkg::CODE_LEN_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_FETCH,
		S_CMP,
		S_FIN
	} state_t;

	ccm_pkg::cfg_t cfg;

	logic [ccm_pkg::INDEX_W-1:0] in_index;
	logic [ccm_pkg::WORD_W-1:0]  in_word;
	logic [ccm_pkg::WORD_W-1:0]  in_sig;
	logic [ccm_pkg::SLEN_W-1:0]  in_slen;
	logic                        in_accept;

	logic [LW-1:0]    len;
	logic [CNT_W-1:0] cnt;
	logic [L-1:0]     mask;
	logic [L-1:0]     top;

	state_t                         state_q;
	logic [LW-1:0]                  len_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [CNT_W-1:0]               idx_q;
	logic [LW-1:0]                  rot_q;
	logic [L-1:0]                   mask_q;
	logic [L-1:0]                   top_q;
	logic [L-1:0]                   prefix_q;
	logic [L-1:0]                   win_q;
	logic [ccm_pkg::ERR_W-1:0]      err_q;
	ccm_pkg::status_t               res_status_q;
	logic [ccm_pkg::INDEX_W-1:0]    res_index_q;
	logic                           m_tvalid_q;
	logic [ccm_pkg::M_TDATA_W-1:0]  m_tdata_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [L-1:0]     ram_wdata;
	logic [L-1:0]     ram_rdata;
	logic             hit;

	assign in_index  = s_tdata[5:0];
	assign in_word   = s_tdata[36:6];
	assign in_sig    = s_tdata[67:37];
	assign in_slen   = s_tdata[73:68];
	assign s_tready  = state_q == S_IDLE;
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign ram_we    = in_accept && s_tuser == ccm_pkg::OP_LOAD
		&& 32'(in_index) < 32'(MAX_CODES);
	assign ram_waddr = IDX_W'(in_index);
	assign ram_wdata = L'(in_word);

	always_comb begin
		len  = (32'(cfg.code_length) > 32'(L)) ? LW'(L) : cfg.code_length;
		cnt  = (32'(cfg.code_count) > 32'(MAX_CODES)) ? CNT_W'(MAX_CODES)
			: CNT_W'(cfg.code_count);
		mask = {L{1'b1}} >> (32'(L) - 32'(len));
		top  = (len == '0) ? '0 : (L'(1) << (len - LW'(1)));
	end

	ccm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ccm_ram #(
		.WIDTH (L),
		.DEPTH (MAX_CODES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	ccm_dist #(
		.W (L)
	) u_dist (
		.a     (win_q),
		.b     (prefix_q),
		.limit (err_q),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			cnt_q        <= '0;
			idx_q        <= '0;
			rot_q        <= '0;
			mask_q       <= '0;
			top_q        <= '0;
			prefix_q     <= '0;
			win_q        <= '0;
			err_q        <= '0;
			res_status_q <= ccm_pkg::ST_INVALID;
			res_index_q  <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept && s_tuser == ccm_pkg::OP_MATCH) begin
						len_q        <= len;
						cnt_q        <= cnt;
						idx_q        <= '0;
						mask_q       <= mask;
						top_q        <= top;
						prefix_q     <= L'(in_sig) & mask;
						err_q        <= cfg.allowed_errors;
						res_index_q  <= '0;
						if (in_slen == '0) begin
							res_status_q <= ccm_pkg::ST_INVALID;
							state_q      <= S_FIN;
						end else if (in_slen < {1'b0, len}) begin
							res_status_q <= ccm_pkg::ST_SHORT;
							state_q      <= S_FIN;
						end else if (len == '0 || cnt == '0) begin
							res_status_q <= ccm_pkg::ST_INVALID;
							state_q      <= S_FIN;
						end else begin
							res_status_q <= ccm_pkg::ST_INVALID;
							state_q      <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					win_q   <= ram_rdata & mask_q;
					rot_q   <= '0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						res_status_q <= ccm_pkg::ST_MATCH;
						res_index_q  <= ccm_pkg::INDEX_W'(idx_q);
						state_q      <= S_FIN;
					end else if (rot_q == len_q - LW'(1)) begin
						idx_q <= idx_q + CNT_W'(1);
						if (idx_q + CNT_W'(1) == cnt_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_READ;
						end
					end else begin
						win_q <= (win_q >> 1) | (win_q[0] ? top_q : '0);
						rot_q <= rot_q + LW'(1);
					end
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {res_index_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import ccm_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [INDEX_W-1:0] idx;
	} match_res_t;

	typedef struct packed {
		logic                  reconf;
		logic [CODE_LEN_W-1:0] len;
		logic [ERR_W-1:0]      err;
		logic [COUNT_W-1:0]    cnt;
		opcode_t               op;
		logic [INDEX_W-1:0]    index;
		logic [WORD_W-1:0]     word;
		logic [WORD_W-1:0]     sig;
		logic [SLEN_W-1:0]     slen;
		logic                  known;
		status_t               status;
		logic [INDEX_W-1:0]    midx;
	} stim_row_t;

	localparam int DIR_ROWS = 22;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_ADDR_W-1:0]   paddr;
	logic [APB_DATA_W-1:0]   pwdata;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;
	logic                    s_tvalid;
	logic                    s_tready;
	// code_index[5:0], code_word[36:6], signal_bits[67:37], signal_length[73:68], zeros
	logic [S_TDATA_W-1:0]    s_tdata;
	// opcode[0]
	logic                    s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	// status[1:0], matched_index[7:2]
	logic [M_TDATA_W-1:0]    m_tdata;

	logic [WORD_W-1:0]       code_mem [MAX_CODES_DEF];
	logic [CODE_LEN_W-1:0]   cfg_len;
	logic [ERR_W-1:0]        cfg_err;
	logic [COUNT_W-1:0]      cfg_cnt;
	match_res_t              pending_results [$];
	int                      fail_cnt;
	int                      burst_left;
	int                      rdy_mode;
	int                      rdy_left;
	logic [12:0]             rdy_pat;
	match_res_t              got_res;
	match_res_t              want_res;
	stim_row_t               dir_rows [DIR_ROWS];

	cyclic_code_match_with_tolerance uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [WORD_W-1:0] rotate_window(input logic [WORD_W-1:0] c,
		input int len, input int by);
		logic [WORD_W-1:0] r;
		r = '0;
		for (int j = 0; j < len; j++)
			r[j] = c[(j + by) % len];
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] len_mask(input int len);
		logic [31:0] m;
		m = (32'd1 << len) - 32'd1;
		return m[WORD_W-1:0];
	endfunction

	function automatic match_res_t search_table(input logic [WORD_W-1:0] sig,
		input logic [SLEN_W-1:0] slen);
		int len;
		int cnt;
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] prefix;
		logic [WORD_W-1:0] c;
		match_res_t r;
		len = (cfg_len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : int'(cfg_len);
		cnt = (cfg_cnt > MAX_CODES_DEF) ? MAX_CODES_DEF : int'(cfg_cnt);
		r.status = ST_INVALID;
		r.idx = '0;
		if (slen == 0)
			return r;
		if (slen < len) begin
			r.status = ST_SHORT;
			return r;
		end
		mask = len_mask(len);
		prefix = sig & mask;
		for (int i = 0; i < cnt; i++) begin
			c = code_mem[i] & mask;
			for (int p = 0; p < len; p++) begin
				if ($countones(rotate_window(c, len, p) ^ prefix) <= cfg_err) begin
					r.status = ST_MATCH;
					r.idx = INDEX_W'(i);
					return r;
				end
			end
		end
		return r;
	endfunction

	task automatic write_reg(input reg_idx_t ri, input logic [APB_DATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(ri) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	task automatic program_cfg(input logic [CODE_LEN_W-1:0] len, input logic [ERR_W-1:0] err,
		input logic [COUNT_W-1:0] cnt);
		write_reg(REG_CODE_LENGTH, APB_DATA_W'(len));
		write_reg(REG_ALLOWED_ERRORS, APB_DATA_W'(err));
		write_reg(REG_CODE_COUNT, APB_DATA_W'(cnt));
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_len = len;
		cfg_err = err;
		cfg_cnt = cnt;
		@(negedge clk);
	endtask

	task automatic drain_block(input int extra);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic send_item(input opcode_t op, input logic [INDEX_W-1:0] index,
		input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] sig,
		input logic [SLEN_W-1:0] slen, input logic known, input match_res_t typed);
		int gap;
		match_res_t exp_res;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, slen, sig, word, index};
		do @(posedge clk); while (!s_tready);
		if (op == OP_LOAD) begin
			code_mem[index] = word;
		end else begin
			exp_res = known ? typed : search_table(sig, slen);
			pending_results = {pending_results, exp_res};
		end
		@(negedge clk);
	endtask

	task automatic send_random(input int load_pct, input int good_pct);
		int r;
		int len;
		int eff;
		int i;
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] sig;
		logic [SLEN_W-1:0] slen;
		r = $urandom_range(0, 99);
		len = int'(cfg_len);
		eff = (cfg_cnt > MAX_CODES_DEF) ? MAX_CODES_DEF : int'(cfg_cnt);
		if (r < load_pct) begin
			send_item(OP_LOAD, INDEX_W'($urandom), WORD_W'($urandom), WORD_W'($urandom),
				SLEN_W'($urandom), 1'b0, '0);
			return;
		end
		sig = WORD_W'($urandom);
		slen = SLEN_W'($urandom);
		if (r < load_pct + good_pct && eff > 0 && len > 0) begin
			i = $urandom_range(0, eff - 1);
			mask = len_mask(len);
			sig = (sig & ~mask) |
				rotate_window(code_mem[i] & mask, len, $urandom_range(0, len - 1));
			repeat ($urandom_range(0, int'(cfg_err) + 1))
				sig[$urandom_range(0, len - 1)] ^= 1'b1;
			slen = SLEN_W'($urandom_range(len, 63));
		end else if ($urandom_range(0, 3) == 0) begin
			slen = (len > 0) ? SLEN_W'($urandom_range(0, len - 1)) : '0;
		end
		send_item(OP_MATCH, INDEX_W'($urandom), WORD_W'($urandom), sig, slen, 1'b0, '0);
	endtask

	always @(negedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 2);
			rdy_left = $urandom_range(20, 200);
		end
		rdy_left--;
		case (rdy_mode)
			0: m_tready <= 1'b1;
			1: begin
				m_tready <= rdy_pat[0];
				rdy_pat = {rdy_pat[0], rdy_pat[12:1]};
			end
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res.status = status_t'(m_tdata[1:0]);
			got_res.idx = m_tdata[7:2];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d index %0d",
					$time, got_res.status, got_res.idx);
				fail_cnt++;
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.status !== want_res.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want_res.status, got_res.status);
					fail_cnt++;
				end
				if (got_res.idx !== want_res.idx) begin
					$display("%0t: matched_index mismatch, expected %0d, actual %0d",
						$time, want_res.idx, got_res.idx);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		#(60_000_000);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		logic [CODE_LEN_W-1:0] ph_len [12];
		logic [ERR_W-1:0]      ph_err [12];
		logic [COUNT_W-1:0]    ph_cnt [12];
		int                    ph_items [12];
		stim_row_t             row;

		dir_rows = '{
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h7FFFFFFF, 6'd0,
				1'b1, ST_INVALID, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h7FFFFFFF, 6'd15,
				1'b1, ST_SHORT, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h0, 6'd16,
				1'b1, ST_INVALID, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd63, 31'h7FFFFFFF, 31'h7FFFFFFF, 6'd63,
				1'b1, ST_INVALID, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_LOAD, 6'd0, 31'h00000001, 31'h0, 6'd0,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_LOAD, 6'd1, 31'h7FFFFFFF, 31'h7FFFFFFF, 6'd63,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_LOAD, 6'd2, 31'h2AAAAAAA, 31'h0, 6'd0,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_LOAD, 6'd3, 31'h0000F0F0, 31'h0, 6'd0,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_LOAD, 6'd63, 31'h12345678, 31'h0, 6'd0,
				1'b0, ST_MATCH, 6'd0},
			'{1'b1, 5'd16, 5'd0, 7'd4, OP_MATCH, 6'd0, 31'h0, 31'h7FFF8000, 6'd16,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h0000FFFF, 6'd20,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h00005555, 6'd31,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h00000F0F, 6'd63,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h000000FF, 6'd16,
				1'b0, ST_MATCH, 6'd0},
			'{1'b1, 5'd16, 5'd1, 7'd4, OP_MATCH, 6'd0, 31'h0, 31'h0, 6'd16,
				1'b0, ST_MATCH, 6'd0},
			'{1'b1, 5'd31, 5'd31, 7'd1, OP_MATCH, 6'd0, 31'h0, 31'h0, 6'd31,
				1'b1, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h7FFFFFFF, 6'd30,
				1'b1, ST_SHORT, 6'd0},
			'{1'b1, 5'd1, 5'd0, 7'd4, OP_MATCH, 6'd0, 31'h0, 31'h00000001, 6'd1,
				1'b0, ST_MATCH, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h7FFFFFFE, 6'd1,
				1'b0, ST_MATCH, 6'd0},
			'{1'b1, 5'd0, 5'd0, 7'd4, OP_MATCH, 6'd0, 31'h0, 31'h7FFFFFFF, 6'd63,
				1'b1, ST_INVALID, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_MATCH, 6'd0, 31'h0, 31'h0, 6'd0,
				1'b1, ST_INVALID, 6'd0},
			'{1'b0, 5'd0, 5'd0, 7'd0, OP_LOAD, 6'd5, 31'h0, 31'h0, 6'd0,
				1'b0, ST_MATCH, 6'd0}
		};

		ph_len   = '{5'd16, 5'd31, 5'd1,  5'd31, 5'd0,  5'd8,  5'd24, 5'd31, 5'd5,  5'd0, 5'd0, 5'd0};
		ph_err   = '{5'd0,  5'd0,  5'd0,  5'd31, 5'd3,  5'd2,  5'd4,  5'd2,  5'd1,  5'd0, 5'd0, 5'd0};
		ph_cnt   = '{7'd8,  7'd64, 7'd127, 7'd64, 7'd64, 7'd12, 7'd6,  7'd4,  7'd20, 7'd0, 7'd0, 7'd0};
		ph_items = '{40,    15,    15,    10,    10,    40,    40,    40,    40,    25,   25,   25};
		for (int k = 9; k < 12; k++) begin
			ph_len[k] = CODE_LEN_W'($urandom_range(1, 31));
			ph_err[k] = ERR_W'($urandom_range(0, 4));
			ph_cnt[k] = COUNT_W'($urandom_range(1, 16));
		end

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		fail_cnt = 0;
		burst_left = 0;
		rdy_mode = 0;
		rdy_left = 0;
		rdy_pat = 13'b1011001110001;
		cfg_len = CODE_LEN_RST;
		cfg_err = '0;
		cfg_cnt = '0;
		for (int i = 0; i < MAX_CODES_DEF; i++)
			code_mem[i] = '0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			row = dir_rows[r];
			if (row.reconf) begin
				drain_block(20);
				program_cfg(row.len, row.err, row.cnt);
			end
			send_item(row.op, row.index, row.word, row.sig, row.slen, row.known,
				'{row.status, row.midx});
		end

		for (int i = 0; i < MAX_CODES_DEF; i++)
			send_item(OP_LOAD, INDEX_W'(i), WORD_W'($urandom), WORD_W'($urandom),
				SLEN_W'($urandom), 1'b0, '0);

		for (int k = 0; k < 12; k++) begin
			drain_block(20);
			program_cfg(ph_len[k], ph_err[k], ph_cnt[k]);
			repeat (ph_items[k]) send_random(20, 60);
		end

		drain_block(2500);
		if (fail_cnt == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

/* files.f */
sv/ccm_pkg.sv
sv/ccm_ram.sv
sv/ccm_dist.sv
sv/ccm_regs.sv
sv/cyclic_code_match_with_tolerance.sv
test/tb_top.sv
